// ===== rtl/mrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

    localparam int TIME_W   = 32;
    localparam int STATUS_W = 8;
    localparam int DATA_W   = 7;
    localparam int Q_W      = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // time plus or minus a signed offset, plus half a quantum
    localparam int ANOW_W = TIME_W + 2;
    localparam int NUM_W  = TIME_W + 3;
    // dividend bits fed to the serial remainder (nonnegative numerator)
    localparam int DIV_STEPS = TIME_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [3:0] CMD_KEY_OFF = 4'h8;
    localparam logic [3:0] CMD_KEY_ON  = 4'h9;

    localparam logic [MODE_W-1:0] MODE_INDEPENDENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPROX      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXACT       = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET      = MODE_APPROX;
    localparam logic [Q_W-1:0]    QUANTUM_RESET   = 16'd10;
    localparam logic [Q_W-1:0]    THRESHOLD_RESET = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION_MODE = 2'd0,
        CFG_QUANTUM       = 2'd1,
        CFG_THRESHOLD     = 2'd2
    } cfg_idx_t;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_JOIN  = 8'b0000_0100,
        S_SHIFT = 8'b0000_1000,
        S_HALF  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/midi_rhythm_quantizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// MIDI rhythm quantizer. Each accepted event beat yields exactly one result beat:
// the event with its time snapped to the nearest multiple of the quantum (chords
// within the threshold share the previous output time, key-off leaves with
// velocity zero), or the end-of-stream marker. Any other event passes through
// chord join, note-off shift, half-quantum add, a bit-serial remainder by the
// quantum, which sets the rate, and a final clamp before its result is loaded.
// Exact-duration note-offs and negative numerators skip the remainder; an
// end-of-stream beat goes straight to completion. One event is in flight at a
// time; the output register lets the next event be accepted while a result waits.
// After reset the CHANNELS*KEYS offset table is cleared one entry per cycle
// (2048 entries at the defaults) before the first event is accepted;
// configuration writes are taken at any time but must only be issued while idle.
module midi_rhythm_quantizer #(
    parameter int CHANNELS = 16,
    parameter int KEYS     = 128
) (
    input  wire                                   clk,
    input  wire                                   rst_n,

    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [mrq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [mrq_pkg::Q_W-1:0]               cfg_data,

    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  [mrq_pkg::TIME_W-1:0]            event_time,
    input  wire  [mrq_pkg::STATUS_W-1:0]          status_byte,
    input  wire  [mrq_pkg::DATA_W-1:0]            data_one,
    input  wire  [mrq_pkg::DATA_W-1:0]            data_two,
    input  wire                                   end_of_stream,

    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [mrq_pkg::TIME_W-1:0]            out_time,
    output logic [mrq_pkg::STATUS_W-1:0]          out_status,
    output logic [mrq_pkg::DATA_W-1:0]            out_data_one,
    output logic [mrq_pkg::DATA_W-1:0]            out_data_two,
    output logic                                  is_end_marker
);

    import mrq_pkg::*;

    localparam int DEPTH  = CHANNELS * KEYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // control
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // configuration and running times
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [Q_W-1:0]       quantum_reg, quantum_next;
    logic [Q_W-1:0]       threshold_reg, threshold_next;
    logic [TIME_W-1:0]    prev_reg, prev_next;
    logic [TIME_W-1:0]    last_out_reg, last_out_next;
    logic [TIME_W-1:0]    last_adj_reg, last_adj_next;

    // working payload
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [DATA_W-1:0]    d1_reg, d1_next;
    logic [DATA_W-1:0]    d2_reg, d2_next;
    logic                 eos_reg, eos_next;
    logic [ANOW_W-1:0]    anow_reg, anow_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DIV_STEPS-1:0] div_reg, div_next;
    logic [Q_W-1:0]       rem_reg, rem_next;
    logic [TIME_W-1:0]    onow_reg, onow_next;
    logic [TIME_W-1:0]    mem_rd_reg;

    logic [TIME_W-1:0]    out_time_reg, out_time_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [DATA_W-1:0]    out_d1_reg, out_d1_next;
    logic [DATA_W-1:0]    out_d2_reg, out_d2_next;
    logic                 out_eos_reg, out_eos_next;

    logic [TIME_W-1:0]    mem [DEPTH];
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [TIME_W-1:0]    mem_wd;
    logic [ADDR_W-1:0]    rd_addr;

    logic                 in_fire;
    logic                 out_load;
    logic [Q_W-1:0]       q_eff;
    logic [3:0]           cmd;
    logic [3:0]           chan;
    logic                 is_key_off;
    logic                 is_note;
    logic [DATA_W-1:0]    vel;
    logic                 in_table;
    logic                 note_off;
    logic [TIME_W-1:0]    off;

    logic signed [TIME_W:0]  join_diff;
    logic                    join_hit;
    logic signed [NUM_W-1:0] num_calc;
    logic [Q_W:0]            trial;
    logic                    trial_ge;
    logic signed [NUM_W-1:0] cand;
    logic signed [NUM_W-1:0] off_diff;
    logic [TIME_W-1:0]       off_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign q_eff = (quantum_reg == '0) ? Q_W'(1) : quantum_reg;

    assign cmd        = status_reg[7:4];
    assign chan       = status_reg[3:0];
    assign is_key_off = (cmd == CMD_KEY_OFF);
    assign is_note    = is_key_off || (cmd == CMD_KEY_ON);
    assign vel        = is_key_off ? '0 : d2_reg;
    assign in_table   = is_note && (32'(chan) < CHANNELS) && (32'(d1_reg) < KEYS);
    assign note_off   = is_note && (vel == '0);
    assign off        = in_table ? mem_rd_reg : '0;

    assign rd_addr = ADDR_W'(32'(status_byte[3:0]) * KEYS + 32'(data_one));

    assign join_diff = $signed({1'b0, time_reg}) - $signed({1'b0, prev_reg});
    assign join_hit  = join_diff <= $signed({{(TIME_W - Q_W + 1){1'b0}}, threshold_reg});

    // exact note-off: time plus offset; otherwise adjusted time plus half a quantum
    assign num_calc = (note_off && mode_reg == MODE_EXACT)
        ? $signed({3'b000, time_reg}) + $signed({{3{off[TIME_W-1]}}, off})
        : $signed({anow_reg[ANOW_W-1], anow_reg})
          + $signed({{(NUM_W - Q_W + 1){1'b0}}, q_eff[Q_W-1:1]});

    assign trial    = {rem_reg, div_reg[DIV_STEPS-1]};
    assign trial_ge = trial >= {1'b0, q_eff};

    assign cand = num_reg - $signed({{(NUM_W - Q_W){1'b0}}, rem_reg});

    assign off_diff = $signed({3'b000, onow_reg}) - $signed({anow_reg[ANOW_W-1], anow_reg});
    always_comb
    begin
        if (off_diff > $signed({4'b0000, 31'h7FFF_FFFF}))
        begin
            off_sat = 32'h7FFF_FFFF;
        end
        else if (off_diff < $signed({4'b1111, 31'h0}))
        begin
            off_sat = 32'h8000_0000;
        end
        else
        begin
            off_sat = off_diff[TIME_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        mode_next       = mode_reg;
        quantum_next    = quantum_reg;
        threshold_next  = threshold_reg;
        prev_next       = prev_reg;
        last_out_next   = last_out_reg;
        last_adj_next   = last_adj_reg;
        time_next       = time_reg;
        status_next     = status_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        eos_next        = eos_reg;
        anow_next       = anow_reg;
        num_next        = num_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        onow_next       = onow_reg;
        out_time_next   = out_time_reg;
        out_status_next = out_status_reg;
        out_d1_next     = out_d1_reg;
        out_d2_next     = out_d2_reg;
        out_eos_next    = out_eos_reg;
        mem_we          = 1'b0;
        mem_wa          = clr_cnt_reg;
        mem_wd          = '0;

        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DURATION_MODE: mode_next      = cfg_data[MODE_W-1:0];
                CFG_QUANTUM:       quantum_next   = cfg_data;
                CFG_THRESHOLD:     threshold_next = cfg_data;
                default:           ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    time_next   = event_time;
                    status_next = status_byte;
                    d1_next     = data_one;
                    d2_next     = data_two;
                    eos_next    = end_of_stream;
                    state_next  = end_of_stream ? S_DONE : S_JOIN;
                end
            end
            S_JOIN:
            begin
                anow_next  = {2'b00, (join_hit ? last_out_reg : time_reg)};
                prev_next  = time_reg;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (note_off && mode_reg == MODE_APPROX)
                begin
                    anow_next = anow_reg + {{2{off[TIME_W-1]}}, off};
                end
                state_next = S_HALF;
            end
            S_HALF:
            begin
                if (anow_reg[ANOW_W-1])
                begin
                    last_adj_next = '0;
                end
                else if (anow_reg[TIME_W])
                begin
                    last_adj_next = '1;
                end
                else
                begin
                    last_adj_next = anow_reg[TIME_W-1:0];
                end
                num_next     = num_calc;
                div_next     = num_calc[DIV_STEPS-1:0];
                rem_next     = '0;
                bit_cnt_next = '0;
                if ((note_off && mode_reg == MODE_EXACT) || num_calc[NUM_W-1])
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next     = trial_ge ? Q_W'(trial - {1'b0, q_eff}) : trial[Q_W-1:0];
                div_next     = {div_reg[DIV_STEPS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                if (bit_cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // a negative grid point always falls below the last output time
                if (cand < $signed({3'b000, last_out_reg}))
                begin
                    onow_next = last_out_reg;
                end
                else if (cand > $signed({3'b000, {TIME_W{1'b1}}}))
                begin
                    onow_next = '1;
                end
                else
                begin
                    onow_next = cand[TIME_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (eos_reg)
                    begin
                        out_time_next   = (last_adj_reg > last_out_reg) ? last_adj_reg
                                                                        : last_out_reg;
                        out_status_next = '0;
                        out_d1_next     = '0;
                        out_d2_next     = '0;
                        out_eos_next    = 1'b1;
                        prev_next       = '0;
                        last_out_next   = '0;
                        last_adj_next   = '0;
                    end
                    else
                    begin
                        out_time_next   = onow_reg;
                        out_status_next = status_reg;
                        out_d1_next     = d1_reg;
                        out_d2_next     = vel;
                        out_eos_next    = 1'b0;
                        last_out_next   = onow_reg;
                        if (mode_reg != MODE_INDEPENDENT && in_table && vel != '0)
                        begin
                            mem_we = 1'b1;
                            mem_wa = ADDR_W'(32'(chan) * KEYS + 32'(d1_reg));
                            mem_wd = off_sat;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_RESET;
            quantum_reg   <= QUANTUM_RESET;
            threshold_reg <= THRESHOLD_RESET;
            prev_reg      <= '0;
            last_out_reg  <= '0;
            last_adj_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            quantum_reg   <= quantum_next;
            threshold_reg <= threshold_next;
            prev_reg      <= prev_next;
            last_out_reg  <= last_out_next;
            last_adj_reg  <= last_adj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg       <= time_next;
        status_reg     <= status_next;
        d1_reg         <= d1_next;
        d2_reg         <= d2_next;
        eos_reg        <= eos_next;
        anow_reg       <= anow_next;
        num_reg        <= num_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        onow_reg       <= onow_next;
        out_time_reg   <= out_time_next;
        out_status_reg <= out_status_next;
        out_d1_reg     <= out_d1_next;
        out_d2_reg     <= out_d2_next;
        out_eos_reg    <= out_eos_next;
    end

    // offset table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (in_fire)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_time      = out_time_reg;
    assign out_status    = out_status_reg;
    assign out_data_one  = out_d1_reg;
    assign out_data_two  = out_d2_reg;
    assign is_end_marker = out_eos_reg;

    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("accepted beat did not start processing");

    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !eos_reg) |-> onow_reg >= last_out_reg)
        else $error("output time would decrease");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> bit_cnt_reg < CNT_W'(DIV_STEPS))
        else $error("remainder step counter overran");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result register loaded outside completion");

endmodule

`default_nettype wire

// ===== verif/tb_midi_rhythm_quantizer.sv =====
`timescale 1ns / 1ps

module tb_midi_rhythm_quantizer;

    import mrq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [3:0] CMD_CONTROL = 4'hB;
    localparam logic [3:0] CMD_PROGRAM = 4'hC;
    localparam logic [3:0] CMD_SYSTEM  = 4'hF;

    localparam longint TIME_MAX   = 64'sd4294967295;
    localparam longint OFFSET_MIN = -64'sd2147483648;
    localparam longint OFFSET_MAX = 64'sd2147483647;

    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   vel;
        logic                marker;
    } quantized_beat_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0]       cfg_data  = '0;

    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [TIME_W-1:0]   event_time    = '0;
    logic [STATUS_W-1:0] status_byte   = '0;
    logic [DATA_W-1:0]   data_one      = '0;
    logic [DATA_W-1:0]   data_two      = '0;
    logic                end_of_stream = 1'b0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [TIME_W-1:0]   out_time;
    logic [STATUS_W-1:0] out_status;
    logic [DATA_W-1:0]   out_data_one;
    logic [DATA_W-1:0]   out_data_two;
    logic                is_end_marker;

    // predictor state
    logic [MODE_W-1:0] mode_reg;
    logic [Q_W-1:0]    grid;
    logic [Q_W-1:0]    thr;
    logic [TIME_W-1:0] prev_in;
    logic [TIME_W-1:0] last_out;
    logic [TIME_W-1:0] last_adj;
    int                offset_tbl [0:2047];

    quantized_beat_t quantized_beats[$];
    logic [10:0]     held_notes[$];
    logic [TIME_W-1:0] song_time = '0;

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    midi_rhythm_quantizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .event_time    (event_time),
        .status_byte   (status_byte),
        .data_one      (data_one),
        .data_two      (data_two),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_time      (out_time),
        .out_status    (out_status),
        .out_data_one  (out_data_one),
        .out_data_two  (out_data_two),
        .is_end_marker (is_end_marker)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic quantized_beat_t quantize_event(logic [TIME_W-1:0] when,
                                                       logic [STATUS_W-1:0] st,
                                                       logic [DATA_W-1:0] key,
                                                       logic [DATA_W-1:0] vel_in,
                                                       logic eos);
        quantized_beat_t r;
        longint q;
        longint last_t;
        longint now_in;
        longint anow;
        longint onow;
        longint off;
        logic [DATA_W-1:0] vel;
        logic is_note;
        logic exact;
        logic [10:0] slot;
        q = (grid == 0) ? 64'sd1 : longint'({48'b0, grid});
        last_t = longint'({32'b0, last_out});
        now_in = longint'({32'b0, when});
        if (eos)
        begin
            r.stamp  = (last_adj > last_out) ? last_adj : last_out;
            r.status = '0;
            r.key    = '0;
            r.vel    = '0;
            r.marker = 1'b1;
            prev_in  = '0;
            last_out = '0;
            last_adj = '0;
            return r;
        end
        // chord join, also taken for earlier times
        anow = (now_in - longint'({32'b0, prev_in}) <= longint'({48'b0, thr})) ? last_t : now_in;
        prev_in = when;
        vel = (st[7:4] == CMD_KEY_OFF) ? '0 : vel_in;
        is_note = (st[7:4] == CMD_KEY_OFF) || (st[7:4] == CMD_KEY_ON);
        slot = {st[3:0], key};
        off = is_note ? longint'(offset_tbl[slot]) : 64'sd0;
        exact = is_note && vel == 0 && mode_reg == MODE_EXACT;
        if (is_note && vel == 0 && mode_reg == MODE_APPROX)
            anow = anow + off;
        if (exact)
            onow = now_in + off;
        else
        begin
            onow = anow + q / 2;
            onow = onow - onow % q;
        end
        if (onow < last_t)
            onow = last_t;
        onow = clip(onow, 0, TIME_MAX);
        if (mode_reg != MODE_INDEPENDENT && is_note && vel != 0)
            offset_tbl[slot] = int'(clip(onow - anow, OFFSET_MIN, OFFSET_MAX));
        last_out = onow[TIME_W-1:0];
        last_adj = 32'(clip(anow, 0, TIME_MAX));
        r.stamp  = onow[TIME_W-1:0];
        r.status = st;
        r.key    = key;
        r.vel    = vel;
        r.marker = 1'b0;
        return r;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR: %s", msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic send_event(logic [TIME_W-1:0] when, logic [STATUS_W-1:0] st,
                              logic [DATA_W-1:0] key, logic [DATA_W-1:0] vel,
                              logic eos);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        event_time    <= when;
        status_byte   <= st;
        data_one      <= key;
        data_two      <= vel;
        end_of_stream <= eos;
        do @(posedge clk); while (in_ready !== 1'b1);
        quantized_beats.push_back(quantize_event(when, st, key, vel, eos));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_DURATION_MODE: mode_reg = value[MODE_W-1:0];
            CFG_QUANTUM:       grid = value;
            CFG_THRESHOLD:     thr = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // sender holds off until every beat is back and the block is idle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (quantized_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        quantized_beat_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (quantized_beats.size() == 0)
                report_error("result beat with nothing expected");
            else
            begin
                want = quantized_beats.pop_front();
                check_field("out_time", out_time, want.stamp);
                check_field("out_status", 32'(out_status), 32'(want.status));
                check_field("out_data_one", 32'(out_data_one), 32'(want.key));
                check_field("out_data_two", 32'(out_data_two), 32'(want.vel));
                check_field("is_end_marker", 32'(is_end_marker), 32'(want.marker));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_defaults();
        send_event(32'd0, {CMD_KEY_ON, 4'h0}, 7'd60, 7'd100, 1'b0);
        send_event(32'd1, {CMD_KEY_ON, 4'h0}, 7'd64, 7'd100, 1'b0);
        send_event(32'd23, {CMD_KEY_OFF, 4'h0}, 7'd60, 7'd64, 1'b0);
        send_event(32'd37, {CMD_KEY_ON, 4'h0}, 7'd64, 7'd0, 1'b0);
        send_event(32'hFFFF_FFFF, {CMD_SYSTEM, 4'hF}, 7'd127, 7'd127, 1'b0);
        send_event(32'd5, 8'h00, 7'd0, 7'd0, 1'b0);
        send_event(32'd123, {CMD_KEY_ON, 4'hF}, 7'd1, 7'd1, 1'b1);
    endtask

    task automatic test_exact_durations();
        drain_results();
        write_reg(CFG_DURATION_MODE, 16'(MODE_EXACT));
        write_reg(CFG_QUANTUM, 16'hFFFF);
        write_reg(CFG_THRESHOLD, 16'd0);
        send_event(32'd40000, {CMD_KEY_ON, 4'hF}, 7'd127, 7'd1, 1'b0);
        send_event(32'd40001, {CMD_KEY_OFF, 4'hF}, 7'd127, 7'd0, 1'b0);
        send_event(32'hFFFF_0000, {CMD_KEY_ON, 4'h3}, 7'd5, 7'd127, 1'b0);
        send_event(32'd0, 8'h00, 7'd0, 7'd0, 1'b1);
    endtask

    task automatic test_independent_offs();
        drain_results();
        write_reg(CFG_DURATION_MODE, 16'(MODE_INDEPENDENT));
        write_reg(CFG_QUANTUM, 16'd0);
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        send_event(32'd1000, {CMD_KEY_ON, 4'h1}, 7'd7, 7'd90, 1'b0);
        send_event(32'd70000, {CMD_KEY_OFF, 4'h1}, 7'd7, 7'd0, 1'b0);
        send_event(32'd70003, {CMD_KEY_ON, 4'h1}, 7'd7, 7'd0, 1'b0);
        send_event(32'd9, 8'h00, 7'd0, 7'd0, 1'b1);
    endtask

    task automatic test_mode_three();
        drain_results();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_DURATION_MODE, 16'hFFFF);
        write_reg(CFG_QUANTUM, 16'd7);
        write_reg(CFG_THRESHOLD, 16'd1);
        send_event(32'd50, {CMD_KEY_ON, 4'h2}, 7'd30, 7'd10, 1'b0);
        send_event(32'd60, {CMD_KEY_OFF, 4'h2}, 7'd30, 7'd0, 1'b0);
    endtask

    // note start pushed far past its input time saturates the stored offset
    task automatic test_offset_saturation();
        drain_results();
        write_reg(CFG_DURATION_MODE, 16'(MODE_APPROX));
        write_reg(CFG_QUANTUM, 16'd16);
        write_reg(CFG_THRESHOLD, 16'd0);
        send_event(32'hF000_0000, {CMD_CONTROL, 4'h0}, 7'd1, 7'd2, 1'b0);
        send_event(32'd5, {CMD_PROGRAM, 4'h0}, 7'd3, 7'd0, 1'b0);
        send_event(32'd100, {CMD_KEY_ON, 4'h2}, 7'd9, 7'd50, 1'b0);
        send_event(32'd200, {CMD_KEY_OFF, 4'h2}, 7'd9, 7'd0, 1'b0);
        drain_results();
        write_reg(CFG_DURATION_MODE, 16'(MODE_EXACT));
        send_event(32'hFFFF_FFFF, {CMD_KEY_OFF, 4'h2}, 7'd9, 7'd33, 1'b0);
        send_event(32'd0, 8'h00, 7'd0, 7'd0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int pick;
        int step_cap;
        int idx;
        logic [10:0] slot;
        logic [3:0] chan;
        logic [DATA_W-1:0] key;
        logic [Q_W-1:0] q_pick;
        logic [Q_W-1:0] t_pick;
        for (int phase = 0; phase < 12; phase++)
        begin
            drain_results();
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            case (phase % 6)
                0: q_pick = 16'd1;
                1: q_pick = 16'hFFFF;
                2: q_pick = 16'd0;
                default: q_pick = 16'($urandom_range(200, 2));
            endcase
            case (phase % 5)
                0: t_pick = 16'd0;
                1: t_pick = 16'hFFFF;
                default: t_pick = 16'($urandom_range(40));
            endcase
            write_reg(CFG_DURATION_MODE, 16'((phase / 2) % 4));
            write_reg(CFG_QUANTUM, q_pick);
            write_reg(CFG_THRESHOLD, t_pick);
            step_cap = (grid == 0) ? 4 : 4 * int'(grid);
            repeat (70)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    song_time = song_time + 32'($urandom_range(int'(thr)));
                else if (pick < 80)
                    song_time = song_time + 32'($urandom_range(step_cap));
                else if (pick < 95)
                    song_time = song_time + 32'($urandom_range(300000));
                else
                    song_time = song_time - 32'($urandom_range(50));
                pick = $urandom_range(99);
                chan = 4'($urandom_range(15));
                if (pick < 2)
                    send_event(32'($urandom), 8'($urandom), 7'($urandom), 7'($urandom), 1'b1);
                else if (pick < 12)
                    send_event(32'($urandom), 8'($urandom), 7'($urandom), 7'($urandom), 1'b0);
                else if (pick < 17)
                    send_event({16'hFFFF, 16'($urandom)}, 8'($urandom), 7'($urandom),
                               7'($urandom), 1'b0);
                else if (pick < 25)
                    send_event(song_time, {CMD_CONTROL, chan}, 7'($urandom), 7'($urandom),
                               1'b0);
                else if (held_notes.size() > 0 && (held_notes.size() > 10 || $urandom_range(1)))
                begin
                    idx = $urandom_range(held_notes.size() - 1);
                    slot = held_notes[idx];
                    held_notes.delete(idx);
                    if ($urandom_range(1))
                        send_event(song_time, {CMD_KEY_OFF, slot[10:7]}, slot[6:0],
                                   7'($urandom), 1'b0);
                    else
                        send_event(song_time, {CMD_KEY_ON, slot[10:7]}, slot[6:0], 7'd0, 1'b0);
                end
                else
                begin
                    key = ($urandom_range(3) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(11));
                    held_notes.push_back({chan, key});
                    send_event(song_time, {CMD_KEY_ON, chan}, key, 7'($urandom_range(127, 1)),
                               1'b0);
                end
            end
        end
    endtask

    initial
    begin
        mode_reg = MODE_RESET;
        grid     = QUANTUM_RESET;
        thr      = THRESHOLD_RESET;
        prev_in  = '0;
        last_out = '0;
        last_adj = '0;
        foreach (offset_tbl[i])
            offset_tbl[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_exact_durations();
        test_independent_offs();
        test_mode_three();
        test_offset_saturation();
        test_random_traffic();
        drain_results();
        repeat (60) @(posedge clk);
        if (quantized_beats.size() != 0)
            report_error("expected beats left over at end");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mrq_pkg.sv
rtl/midi_rhythm_quantizer.sv
verif/tb_midi_rhythm_quantizer.sv
